>>> design/nec_ir_pkg.sv
// Shared types and constants for the NEC infrared pulse decoder.
// No dependencies; used by the interfaces and the top level.
package nec_ir_pkg;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned PULSE_W = 14;
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned RPT_W   = 8;
    localparam int unsigned IDLE_W  = 4;
    localparam int unsigned ADDR_W  = 8;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned FRAME_W = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_RISE = 2'd0,
        REQ_FALL = 2'd1,
        REQ_TICK = 2'd2,
        REQ_SCAN = 2'd3
    } t_req;

    typedef enum logic {
        CFG_DEVICE_ADDRESS  = 1'b0,
        CFG_IDLE_TICK_LIMIT = 1'b1
    } t_cfg_idx;

    // Open pulse-width windows in microseconds (bounds excluded)
    localparam logic [PULSE_W-1:0] BIT0_LO   = 14'd300;
    localparam logic [PULSE_W-1:0] BIT0_HI   = 14'd800;
    localparam logic [PULSE_W-1:0] BIT1_LO   = 14'd1400;
    localparam logic [PULSE_W-1:0] BIT1_HI   = 14'd1800;
    localparam logic [PULSE_W-1:0] RPT_LO    = 14'd2200;
    localparam logic [PULSE_W-1:0] RPT_HI    = 14'd2600;
    localparam logic [PULSE_W-1:0] LEADER_LO = 14'd4200;
    localparam logic [PULSE_W-1:0] LEADER_HI = 14'd4700;

    localparam logic [ADDR_W-1:0] ADDR_RESET       = 8'd0;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 4'd14;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic [RPT_W-1:0] repeat_count;
        logic             frame_held;
    } t_rsp;

endpackage

>>> design/nec_ir_if.sv
// Valid/ready channel interfaces for the NEC infrared pulse decoder.
// Depends on nec_ir_pkg for field widths.
interface nec_ir_req_if;
    logic                              valid;
    logic                              ready;
    logic [nec_ir_pkg::REQ_W-1:0]      req_type;
    logic [nec_ir_pkg::PULSE_W-1:0]    pulse_us;

    modport source (output valid, output req_type, output pulse_us, input ready);
    modport sink   (input valid, input req_type, input pulse_us, output ready);
endinterface

interface nec_ir_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [nec_ir_pkg::KEY_W-1:0]      key_code;
    logic [nec_ir_pkg::RPT_W-1:0]      repeat_count;
    logic                              frame_held;

    modport source (output valid, output key_code, output repeat_count,
                    output frame_held, input ready);
    modport sink   (input valid, input key_code, input repeat_count,
                    input frame_held, output ready);
endinterface

>>> design/nec_ir_pulse_decoder.sv
// NEC infrared pulse decoder top level: decode state, config registers, output skid.
// Depends on nec_ir_pkg and the channel interfaces in nec_ir_if.sv.
//
// Usage:
//   i_req carries events: rising edge, falling edge with the high-pulse width
//   in microseconds, 10 ms tick, or scan request. Every accepted transaction
//   produces exactly one transaction on o_rsp with the key (nonzero only on a
//   scan of a valid frame), the repeat count and the frame-held flag.
//   An accepted transaction is registered in the output register, or in the skid
//   while o_rsp stalls. Throughput is one transaction per cycle while o_rsp
//   takes them; the decode is a handful of compares and a shift in the accept cycle.
//   The output side is a two-entry buffer (output register plus skid): while
//   the receiver stalls, one more transaction is accepted, then i_req.ready
//   drops until o_rsp takes the transaction it holds.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) land at the clock edge and
//   are meant for idle periods only.
//   Synchronous reset clears the decode state, restores the address to 0 and
//   the idle limit to 14, and empties the output buffer.
module nec_ir_pulse_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [nec_ir_pkg::CFG_W-1:0]   i_cfg_data,
    nec_ir_req_if.sink                     i_req,
    nec_ir_rsp_if.source                   o_rsp
);

    logic [nec_ir_pkg::ADDR_W-1:0]  r_dev_addr;
    logic [nec_ir_pkg::IDLE_W-1:0]  r_idle_limit;

    logic                            r_leader, n_leader;
    logic                            r_ready_frm, n_ready_frm;
    logic                            r_armed, n_armed;
    logic [nec_ir_pkg::IDLE_W-1:0]  r_idle, n_idle;
    logic [nec_ir_pkg::FRAME_W-1:0] r_bits, n_bits;
    logic [nec_ir_pkg::RPT_W-1:0]   r_rpts, n_rpts;

    nec_ir_pkg::t_rsp r_out, r_skid, n_rsp;
    logic             r_out_vld, r_skid_vld;

    logic [nec_ir_pkg::KEY_W-1:0]   n_key;
    logic                            in_acc, out_pop;
    nec_ir_pkg::t_req                req;
    logic [nec_ir_pkg::PULSE_W-1:0] w;
    logic                            is_bit0, is_bit1, is_rpt, is_leader;
    logic [7:0]                      f_addr, f_naddr, f_cmd, f_ncmd;
    logic                            frame_ok;

    assign i_req.ready = !r_skid_vld;
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_pop     = r_out_vld && o_rsp.ready;

    assign req = nec_ir_pkg::t_req'(i_req.req_type);
    assign w   = i_req.pulse_us;

    assign is_bit0   = (w > nec_ir_pkg::BIT0_LO)   && (w < nec_ir_pkg::BIT0_HI);
    assign is_bit1   = (w > nec_ir_pkg::BIT1_LO)   && (w < nec_ir_pkg::BIT1_HI);
    assign is_rpt    = (w > nec_ir_pkg::RPT_LO)    && (w < nec_ir_pkg::RPT_HI);
    assign is_leader = (w > nec_ir_pkg::LEADER_LO) && (w < nec_ir_pkg::LEADER_HI);

    assign f_addr   = r_bits[31:24];
    assign f_naddr  = r_bits[23:16];
    assign f_cmd    = r_bits[15:8];
    assign f_ncmd   = r_bits[7:0];
    assign frame_ok = (f_addr == ~f_naddr) && (f_addr == r_dev_addr)
                      && (f_cmd == ~f_ncmd);

    always_comb begin
        n_leader    = r_leader;
        n_ready_frm = r_ready_frm;
        n_armed     = r_armed;
        n_idle      = r_idle;
        n_bits      = r_bits;
        n_rpts      = r_rpts;
        n_key       = '0;
        unique case (req)
            nec_ir_pkg::REQ_RISE: begin
                n_armed = 1'b1;
            end
            nec_ir_pkg::REQ_FALL: begin
                n_armed = 1'b0;
                if (r_armed) begin
                    if (r_leader) begin
                        priority if (is_bit0) begin
                            n_bits = {r_bits[nec_ir_pkg::FRAME_W-2:0], 1'b0};
                        end else if (is_bit1) begin
                            n_bits = {r_bits[nec_ir_pkg::FRAME_W-2:0], 1'b1};
                        end else if (is_rpt) begin
                            n_rpts = r_rpts + 1'b1;
                            n_idle = '0;
                        end else begin
                            n_bits = r_bits;
                        end
                    end else if (is_leader) begin
                        n_leader = 1'b1;
                        n_rpts   = '0;
                    end
                end
            end
            nec_ir_pkg::REQ_TICK: begin
                if (r_leader) begin
                    n_armed = 1'b0;
                    if (r_idle == '0) begin
                        n_ready_frm = 1'b1;
                    end
                    if (r_idle < r_idle_limit) begin
                        n_idle = r_idle + 1'b1;
                    end else begin
                        n_leader = 1'b0;
                        n_idle   = '0;
                    end
                end
            end
            nec_ir_pkg::REQ_SCAN: begin
                if (r_ready_frm) begin
                    n_key = frame_ok ? f_cmd : '0;
                    // drop the frame when nothing usable is left
                    if ((n_key == '0) || !r_leader) begin
                        n_ready_frm = 1'b0;
                        n_rpts      = '0;
                    end
                end
            end
            default: begin
                n_armed = r_armed;
            end
        endcase
        n_rsp.key_code     = n_key;
        n_rsp.repeat_count = n_rpts;
        n_rsp.frame_held   = n_leader;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= nec_ir_pkg::ADDR_RESET;
            r_idle_limit <= nec_ir_pkg::IDLE_LIMIT_RESET;
            r_leader     <= 1'b0;
            r_ready_frm  <= 1'b0;
            r_armed      <= 1'b0;
            r_idle       <= '0;
            r_bits       <= '0;
            r_rpts       <= '0;
            r_out_vld    <= 1'b0;
            r_skid_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (nec_ir_pkg::t_cfg_idx'(i_cfg_idx))
                    nec_ir_pkg::CFG_DEVICE_ADDRESS:  r_dev_addr   <= i_cfg_data;
                    nec_ir_pkg::CFG_IDLE_TICK_LIMIT:
                        r_idle_limit <= i_cfg_data[nec_ir_pkg::IDLE_W-1:0];
                    default: r_dev_addr <= r_dev_addr;
                endcase
            end
            if (in_acc) begin
                r_leader    <= n_leader;
                r_ready_frm <= n_ready_frm;
                r_armed     <= n_armed;
                r_idle      <= n_idle;
                r_bits      <= n_bits;
                r_rpts      <= n_rpts;
            end
            // two-entry output buffer: skid fills only when the output register stalls
            if (in_acc && (out_pop || !r_out_vld)) begin
                r_out_vld <= 1'b1;
            end else if (in_acc) begin
                r_skid_vld <= 1'b1;
            end else if (out_pop && r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else if (out_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (out_pop || !r_out_vld)) begin
            r_out <= n_rsp;
        end else if (in_acc) begin
            r_skid <= n_rsp;
        end else if (out_pop && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.key_code     = r_out.key_code;
    assign o_rsp.repeat_count = r_out.repeat_count;
    assign o_rsp.frame_held   = r_out.frame_held;

endmodule

>>> design/nec_ir_chk.sv
// Port-level checker for the NEC infrared pulse decoder, with its bind.
// Depends only on the top level's port signals.
module nec_ir_chk (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  logic i_frame_held,
    input  logic i_key_nz
);

    // a stalled response transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_held))
        else $error("response dropped or changed while stalled");

    // the request side only backs up behind a pending response
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("request ready low with empty output");

    // an accepted request into an empty output shows up next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> i_out_valid)
        else $error("response missing one cycle after request");

    // reset leaves the output empty
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("response valid right after reset");

    // a shown response carries a known key
    a_key_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown(i_key_nz))
        else $error("unknown key with response valid");

endmodule

bind nec_ir_pulse_decoder nec_ir_chk u_nec_ir_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_frame_held (o_rsp.frame_held),
    .i_key_nz     (o_rsp.key_code != 8'd0)
);
